// ===== rtl/y2r_pkg.sv =====
package y2r_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned FracW = 16;
  localparam int unsigned CoefW = 17;
  // Chroma with the offset removed, -128..127.
  localparam int unsigned ChrW  = PixW + 1;
  // Q.16 sums stay within about +/-2^25, so 27 signed bits hold them.
  localparam int unsigned AccW  = 27;

  localparam logic [PixW-1:0]  ChromaOffset = 8'd128;
  localparam logic [CoefW-1:0] CoefRv = 17'd91881;
  localparam logic [CoefW-1:0] CoefGu = 17'd22544;
  localparam logic [CoefW-1:0] CoefGv = 17'd46793;
  localparam logic [CoefW-1:0] CoefBu = 17'd116130;

  typedef logic signed [ChrW-1:0] chroma_t;
  typedef logic signed [AccW-1:0] acc_t;

  // Chroma term of each channel, Q.16.
  typedef struct packed {
    acc_t red;
    acc_t green;
    acc_t blue;
  } chroma_terms_t;

  function automatic acc_t coef_mul(input logic [CoefW-1:0] coef, input chroma_t c);
    logic signed [CoefW:0] coef_s;
    coef_s = signed'({1'b0, coef});
    return acc_t'(coef_s * c);
  endfunction

  function automatic acc_t luma_q16(input logic [PixW-1:0] y);
    return signed'({{(AccW-PixW-FracW){1'b0}}, y, {FracW{1'b0}}});
  endfunction

  // Floor to an integer by dropping the fraction, then clamp to 0..255.
  function automatic logic [PixW-1:0] clamp_q16(input acc_t acc);
    logic [PixW-1:0] res;
    if (acc[AccW-1]) begin
      res = '0;
    end else if (|acc[AccW-2:FracW+PixW]) begin
      res = '1;
    end else begin
      res = acc[FracW+PixW-1:FracW];
    end
    return res;
  endfunction

endpackage

// ===== rtl/y2r_if.sv =====
interface y2r_yuyv_if
  import y2r_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] luma_first;
  logic [PixW-1:0] chroma_blue;
  logic [PixW-1:0] luma_second;
  logic [PixW-1:0] chroma_red;
  logic            frame_end;

  modport source (
    output valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end,
    input  ready
  );
  modport sink (
    input  valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end,
    output ready
  );
endinterface

interface y2r_rgb_if
  import y2r_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] red_first;
  logic [PixW-1:0] green_first;
  logic [PixW-1:0] blue_first;
  logic [PixW-1:0] red_second;
  logic [PixW-1:0] green_second;
  logic [PixW-1:0] blue_second;
  logic            frame_end_out;

  modport source (
    output valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second, frame_end_out,
    input  ready
  );
  modport sink (
    input  valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second, frame_end_out,
    output ready
  );
endinterface

// ===== rtl/yuyv_to_rgb_converter_unit.sv =====
// Channel   Direction  Handshake     Payload
// yuyv_i    in         valid/ready   luma_first, chroma_blue, luma_second, chroma_red, frame_end
// rgb_o     out        valid/ready   red/green/blue first and second, frame_end_out
//
// Four register stages: input capture, chroma multiplies, green term sum,
// luma add with clamp into the output register. One request per cycle unless a
// stall at rgb_o backs up the pipe; each result passes all four registers in order.
// Reset clears only the stage valid bits. A stall at rgb_o holds each full
// stage in place; empty stages keep filling, so up to four requests wait.
module yuyv_to_rgb_converter_unit
  import y2r_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  y2r_yuyv_if.sink          yuyv_i,
  y2r_rgb_if.source         rgb_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || rgb_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign yuyv_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= yuyv_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: capture, chroma offset removed.
  logic [PixW-1:0] y0_s1_q, y1_s1_q;
  chroma_t         cb_s1_q, cr_s1_q;
  logic            fe_s1_q;
  chroma_t         cb_s1_d, cr_s1_d;

  assign cb_s1_d = signed'({1'b0, yuyv_i.chroma_blue}) - signed'({1'b0, ChromaOffset});
  assign cr_s1_d = signed'({1'b0, yuyv_i.chroma_red}) - signed'({1'b0, ChromaOffset});

  always_ff @(posedge clk_i) begin
    if (en1 && yuyv_i.valid) begin
      y0_s1_q <= yuyv_i.luma_first;
      y1_s1_q <= yuyv_i.luma_second;
      cb_s1_q <= cb_s1_d;
      cr_s1_q <= cr_s1_d;
      fe_s1_q <= yuyv_i.frame_end;
    end
  end

  // Stage 2: the four constant multiplies.
  logic [PixW-1:0] y0_s2_q, y1_s2_q;
  acc_t            rv_s2_q, gu_s2_q, gv_s2_q, bu_s2_q;
  logic            fe_s2_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      y0_s2_q <= y0_s1_q;
      y1_s2_q <= y1_s1_q;
      rv_s2_q <= coef_mul(CoefRv, cr_s1_q);
      gu_s2_q <= coef_mul(CoefGu, cb_s1_q);
      gv_s2_q <= coef_mul(CoefGv, cr_s1_q);
      bu_s2_q <= coef_mul(CoefBu, cb_s1_q);
      fe_s2_q <= fe_s1_q;
    end
  end

  // Stage 3: combine the two green products into one term.
  logic [PixW-1:0] y0_s3_q, y1_s3_q;
  chroma_terms_t   terms_s3_q;
  chroma_terms_t   terms_s3_d;
  logic            fe_s3_q;

  assign terms_s3_d.red   = rv_s2_q;
  assign terms_s3_d.green = -(gu_s2_q + gv_s2_q);
  assign terms_s3_d.blue  = bu_s2_q;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      y0_s3_q    <= y0_s2_q;
      y1_s3_q    <= y1_s2_q;
      terms_s3_q <= terms_s3_d;
      fe_s3_q    <= fe_s2_q;
    end
  end

  // Stage 4: add luma, floor and clamp; this is the output register.
  acc_t            y0q, y1q;
  logic [PixW-1:0] r0_q, g0_q, b0_q, r1_q, g1_q, b1_q;
  logic            fe_s4_q;

  assign y0q = luma_q16(y0_s3_q);
  assign y1q = luma_q16(y1_s3_q);

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      r0_q    <= clamp_q16(y0q + terms_s3_q.red);
      g0_q    <= clamp_q16(y0q + terms_s3_q.green);
      b0_q    <= clamp_q16(y0q + terms_s3_q.blue);
      r1_q    <= clamp_q16(y1q + terms_s3_q.red);
      g1_q    <= clamp_q16(y1q + terms_s3_q.green);
      b1_q    <= clamp_q16(y1q + terms_s3_q.blue);
      fe_s4_q <= fe_s3_q;
    end
  end

  assign rgb_o.valid         = v4_q;
  assign rgb_o.red_first     = r0_q;
  assign rgb_o.green_first   = g0_q;
  assign rgb_o.blue_first    = b0_q;
  assign rgb_o.red_second    = r1_q;
  assign rgb_o.green_second  = g1_q;
  assign rgb_o.blue_second   = b1_q;
  assign rgb_o.frame_end_out = fe_s4_q;

endmodule
